// ===== src/ggc_pkg.sv =====
package ggc_pkg;

    localparam int CURL_BITS     = 16;
    localparam int TIME_BITS     = 24;
    localparam int NPROBE        = 5;
    localparam int COOL_BITS     = 24;
    localparam int DT_BITS       = 20;
    localparam int CFG_DATA_BITS = (COOL_BITS > CURL_BITS + 1) ? COOL_BITS : CURL_BITS + 1;
    localparam int TD_BITS       = (TIME_BITS > COOL_BITS) ? TIME_BITS : COOL_BITS;
    localparam int WIDE_BITS     = ((TD_BITS > DT_BITS) ? TD_BITS : DT_BITS) + 1;

    typedef logic signed [CURL_BITS-1:0] curl_t;
    typedef logic signed [CURL_BITS:0]   vel_t;
    typedef logic signed [CURL_BITS+1:0] thr_t;
    typedef logic [TIME_BITS-1:0]        time_t;

    // +1.0, -1.0 and +2.0 in curl fixed point
    localparam curl_t CURL_ONE     = {2'b01, {(CURL_BITS-2){1'b0}}};
    localparam curl_t CURL_NEG_ONE = {2'b11, {(CURL_BITS-2){1'b0}}};
    localparam vel_t  VEL_TWO      = {2'b01, {(CURL_BITS-1){1'b0}}};
    localparam time_t TIME_MAX     = {TIME_BITS{1'b1}};

    typedef enum logic [2:0] {
        REG_MAXIMUM_CURL        = 3'd0,
        REG_MINIMUM_CURL        = 3'd1,
        REG_MAX_CURL_VELOCITY   = 3'd2,
        REG_GRABBED_MAX_CURL_VEL = 3'd3,
        REG_THUMB_STICKINESS    = 3'd4,
        REG_FINGER_STICKINESS   = 3'd5,
        REG_GRAB_COOLDOWN       = 3'd6,
        REG_USE_GRAB_COOLDOWN   = 3'd7
    } reg_index_t;

    typedef struct packed {
        curl_t                 maximum_curl;
        curl_t                 minimum_curl;
        vel_t                  max_curl_velocity;
        vel_t                  grabbed_max_curl_velocity;
        curl_t                 thumb_stickiness;
        curl_t                 finger_stickiness;
        logic [COOL_BITS-1:0]  grab_cooldown;
        logic                  use_grab_cooldown;
    } cfg_t;

    typedef struct packed {
        curl_t                 thumb_curl;
        curl_t                 index_curl;
        curl_t                 middle_curl;
        curl_t                 ring_curl;
        curl_t                 pinky_curl;
        logic [NPROBE-1:0]     touch_mask;
        logic [NPROBE-1:0]     candidate_mask;
        logic                  ignore_temporal;
        logic                  hand_grabbed;
        logic [DT_BITS-1:0]    delta_time;
        logic                  clear_grab;
    } item_t;

    typedef struct packed {
        logic                  grabbing;
        logic                  state_changed;
        logic [NPROBE-1:0]     inside_mask;
        logic [2:0]            inside_count;
    } result_t;

endpackage

// ===== src/ggc_cfg_regs.sv =====
module ggc_cfg_regs
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  ggc_pkg::reg_index_t                 cfg_index,
    input  logic [ggc_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    output ggc_pkg::cfg_t                       cfg
);

    ggc_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.maximum_curl              <= ggc_pkg::CURL_ONE;
            cfg_reg.minimum_curl              <= ggc_pkg::CURL_NEG_ONE;
            cfg_reg.max_curl_velocity         <= ggc_pkg::VEL_TWO;
            cfg_reg.grabbed_max_curl_velocity <= ggc_pkg::VEL_TWO;
            cfg_reg.thumb_stickiness          <= '0;
            cfg_reg.finger_stickiness         <= '0;
            cfg_reg.grab_cooldown             <= '0;
            cfg_reg.use_grab_cooldown         <= 1'b1;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                ggc_pkg::REG_MAXIMUM_CURL:
                    cfg_reg.maximum_curl <= cfg_data[ggc_pkg::CURL_BITS-1:0];
                ggc_pkg::REG_MINIMUM_CURL:
                    cfg_reg.minimum_curl <= cfg_data[ggc_pkg::CURL_BITS-1:0];
                ggc_pkg::REG_MAX_CURL_VELOCITY:
                    cfg_reg.max_curl_velocity <= cfg_data[ggc_pkg::CURL_BITS:0];
                ggc_pkg::REG_GRABBED_MAX_CURL_VEL:
                    cfg_reg.grabbed_max_curl_velocity <= cfg_data[ggc_pkg::CURL_BITS:0];
                ggc_pkg::REG_THUMB_STICKINESS:
                    cfg_reg.thumb_stickiness <= cfg_data[ggc_pkg::CURL_BITS-1:0];
                ggc_pkg::REG_FINGER_STICKINESS:
                    cfg_reg.finger_stickiness <= cfg_data[ggc_pkg::CURL_BITS-1:0];
                ggc_pkg::REG_GRAB_COOLDOWN:
                    cfg_reg.grab_cooldown <= cfg_data[ggc_pkg::COOL_BITS-1:0];
                ggc_pkg::REG_USE_GRAB_COOLDOWN:
                    cfg_reg.use_grab_cooldown <= cfg_data[0];
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== src/ggc_probe.sv =====
module ggc_probe
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                update,
    input  ggc_pkg::curl_t      curl,
    input  logic                touch,
    input  logic                candidate,
    input  logic                old_grab,
    input  logic                ignore_temporal,
    input  ggc_pkg::curl_t      maximum_curl,
    input  ggc_pkg::curl_t      min_curl,
    input  ggc_pkg::vel_t       vel_limit,
    input  ggc_pkg::curl_t      stickiness,
    output logic                inside_now,
    output logic                inside_next
);

    ggc_pkg::curl_t last_curl_reg;
    ggc_pkg::thr_t  threshold_reg;
    logic           inside_reg;

    ggc_pkg::vel_t  vel;
    ggc_pkg::thr_t  threshold_next;
    logic           contact;
    logic           above;

    assign vel = ggc_pkg::vel_t'(curl) - ggc_pkg::vel_t'(last_curl_reg);

    // without candidates the probe keeps contact only while the hand already grabs
    assign contact = (candidate ? touch : old_grab)
                     && (curl < maximum_curl) && (curl > min_curl)
                     && (ignore_temporal || (vel < vel_limit));

    assign threshold_next = ignore_temporal ? ggc_pkg::thr_t'(stickiness)
                          : ggc_pkg::thr_t'(curl) + ggc_pkg::thr_t'(stickiness);

    assign above = ggc_pkg::thr_t'(curl) > threshold_reg;

    always_comb
    begin
        if (!inside_reg || above)
            inside_next = contact;
        else
            inside_next = inside_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_curl_reg <= '0;
            threshold_reg <= '0;
            inside_reg    <= 1'b0;
        end
        else if (update)
        begin
            last_curl_reg <= curl;
            inside_reg    <= inside_next;
            // latch the release threshold only while outside, so it holds from entry on
            if (!inside_reg)
                threshold_reg <= threshold_next;
        end
    end

    assign inside_now = inside_reg;

endmodule

// ===== src/grab_gesture_classifier.sv =====
// Grab gesture classifier. Each input beat is one tracking frame with five
// finger curls (thumb first), touch and candidate masks and the frame time;
// each frame gives exactly one result beat with the grab decision, a change
// flag and the mask and count of fingers inside the object. Per-finger state
// (last curl, inside flag, release threshold), the grab state and the regrab
// cooldown timer live in the block and advance in arrival order (a
// clear_grab frame clears the grab and holds the rest). A beat passes one
// input register, one pass of compare logic and one result register.
// Throughput is one frame per cycle while results are accepted; the only
// loop is the per-frame state update. Configuration takes effect on the
// next frame and should be written while no frame is in flight.
module grab_gesture_classifier
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  ggc_pkg::reg_index_t                 cfg_index,
    input  logic [ggc_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    input  logic                                item_valid,
    output logic                                item_ready,
    input  ggc_pkg::item_t                      item,
    output logic                                result_valid,
    input  logic                                result_ready,
    output ggc_pkg::result_t                    result
);

    ggc_pkg::cfg_t     cfg;

    ggc_pkg::item_t    item_reg;
    logic              item_valid_reg;
    ggc_pkg::result_t  result_reg;
    ggc_pkg::result_t  result_next;
    logic              result_valid_reg;
    logic              grab_state_reg;
    ggc_pkg::time_t    cooldown_reg;
    ggc_pkg::time_t    cooldown_next;

    logic              advance;
    logic              update;
    logic              clr;
    logic              ign;
    ggc_pkg::curl_t    min_curl;
    ggc_pkg::vel_t     vel_limit;
    ggc_pkg::curl_t    curls [ggc_pkg::NPROBE];
    logic [ggc_pkg::NPROBE-1:0] ins_now;
    logic [ggc_pkg::NPROBE-1:0] ins_next;
    logic [ggc_pkg::NPROBE-1:0] ins_shown;
    logic              grab_raw;
    logic              grab_next;
    logic              suppress;
    logic [ggc_pkg::WIDE_BITS-1:0] cool_sum;
    ggc_pkg::time_t    cool_sat;

    function automatic logic [2:0] count_bits(input logic [ggc_pkg::NPROBE-1:0] m);
        logic [2:0] c;
        c = '0;
        for (int i = 0; i < ggc_pkg::NPROBE; i++)
            c = c + 3'(m[i]);
        return c;
    endfunction

    ggc_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // beat handshake: input register feeds result register in one pass
    assign advance    = item_valid_reg && (!result_valid_reg || result_ready);
    assign item_ready = !item_valid_reg || advance;

    assign clr       = item_reg.clear_grab;
    assign ign       = item_reg.ignore_temporal;
    assign update    = advance && !clr;
    assign min_curl  = ign ? ggc_pkg::CURL_NEG_ONE : cfg.minimum_curl;
    assign vel_limit = item_reg.hand_grabbed ? cfg.grabbed_max_curl_velocity
                                             : cfg.max_curl_velocity;

    assign curls[0] = item_reg.thumb_curl;
    assign curls[1] = item_reg.index_curl;
    assign curls[2] = item_reg.middle_curl;
    assign curls[3] = item_reg.ring_curl;
    assign curls[4] = item_reg.pinky_curl;

    for (genvar g = 0; g < ggc_pkg::NPROBE; g++)
    begin : g_probe
        ggc_probe u_probe
        (
            .clk             (clk),
            .rst_n           (rst_n),
            .update          (update),
            .curl            (curls[g]),
            .touch           (item_reg.touch_mask[g]),
            .candidate       (item_reg.candidate_mask[g]),
            .old_grab        (grab_state_reg),
            .ignore_temporal (ign),
            .maximum_curl    (cfg.maximum_curl),
            .min_curl        (min_curl),
            .vel_limit       (vel_limit),
            .stickiness      ((g == 0) ? cfg.thumb_stickiness : cfg.finger_stickiness),
            .inside_now      (ins_now[g]),
            .inside_next     (ins_next[g])
        );
    end

    assign grab_raw = ins_next[0] && (|ins_next[ggc_pkg::NPROBE-1:1]);

    assign suppress = (ggc_pkg::WIDE_BITS'(cooldown_reg) <= ggc_pkg::WIDE_BITS'(cfg.grab_cooldown))
                      && !ign && cfg.use_grab_cooldown;

    assign cool_sum = ggc_pkg::WIDE_BITS'(cooldown_reg) + ggc_pkg::WIDE_BITS'(item_reg.delta_time);
    assign cool_sat = (cool_sum > ggc_pkg::WIDE_BITS'(ggc_pkg::TIME_MAX))
                    ? ggc_pkg::TIME_MAX : cool_sum[ggc_pkg::TIME_BITS-1:0];

    assign grab_next = grab_raw && !suppress;

    always_comb
    begin
        // restart the cooldown on release
        if (grab_state_reg && !grab_next)
            cooldown_next = '0;
        else if (suppress)
            cooldown_next = cool_sat;
        else
            cooldown_next = cooldown_reg;
    end

    assign ins_shown = clr ? ins_now : ins_next;

    always_comb
    begin
        result_next.grabbing      = !clr && grab_next;
        result_next.state_changed = !clr && (grab_next != grab_state_reg);
        result_next.inside_mask   = ins_shown;
        result_next.inside_count  = count_bits(ins_shown);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
            grab_state_reg   <= 1'b0;
            cooldown_reg     <= ggc_pkg::TIME_MAX;
        end
        else
        begin
            if (item_ready)
                item_valid_reg <= item_valid;
            if (advance)
                result_valid_reg <= 1'b1;
            else if (result_ready)
                result_valid_reg <= 1'b0;
            if (advance)
                grab_state_reg <= !clr && grab_next;
            if (update)
                cooldown_reg <= cooldown_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
            item_reg <= item;
        if (advance)
            result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    a_grab_needs_thumb_and_finger: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && result_reg.grabbing
        |-> result_reg.inside_mask[0] && (|result_reg.inside_mask[ggc_pkg::NPROBE-1:1]))
        else $error("grab reported without thumb and another finger inside");

    a_count_matches_mask: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg
        |-> result_reg.inside_count == 3'($countones(result_reg.inside_mask)))
        else $error("inside count differs from inside mask");

    a_state_tracks_result: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |-> grab_state_reg == result_reg.grabbing)
        else $error("grab state differs from last result");

    a_release_restarts_cooldown: assert property (@(posedge clk) disable iff (!rst_n)
        update && grab_state_reg && !grab_next |=> cooldown_reg == '0)
        else $error("cooldown not restarted on release");

    a_changed_flag: assert property (@(posedge clk) disable iff (!rst_n)
        update |=> result_reg.state_changed == (grab_state_reg != $past(grab_state_reg)))
        else $error("change flag inconsistent with grab state");

endmodule
